// ===== sv/ctt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctt_pkg: shared types and constants of the cycle timebase timeout unit
// Function and status codes, sequencer states and arithmetic constants.
// ----------------------------------------------------------------------------
package ctt_pkg;

  // counter width, 16 to 32 bits
  localparam int COUNTER_WIDTH = 32;

  localparam logic [31:0] US_PER_SECOND      = 32'd1000000;
  localparam logic [31:0] US_ROUND_UP        = 32'd999999;
  localparam logic [31:0] MAX_TIMEOUT_CYCLES = 32'h7FFF_FFFF;
  localparam logic [31:0] FREQ_RESET         = 32'd1000000;

  // restoring divider, one quotient bit per cycle
  localparam int DIVIDEND_WIDTH = 64;
  localparam int DIV_CNT_WIDTH  = $clog2(DIVIDEND_WIDTH);
  localparam logic [DIV_CNT_WIDTH-1:0] DIV_LAST_STEP = DIV_CNT_WIDTH'(DIVIDEND_WIDTH - 1);

  typedef enum logic [2:0] {
    FN_TICK        = 3'd0,
    FN_CLEAR       = 3'd1,
    FN_NOW         = 3'd2,
    FN_ELAPSED     = 3'd3,
    FN_CYCLES_TO_US = 3'd4,
    FN_US_TO_CYCLES = 3'd5,
    FN_TIMEOUT_CHECK = 3'd6
  } func_t;

  typedef enum logic [1:0] {
    STATUS_OK           = 2'd0,
    STATUS_IO_ERROR     = 2'd1,
    STATUS_OUT_OF_RANGE = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_LOAD,
    S_DIV,
    S_FIN
  } state_t;

endpackage

// ===== sv/cycle_timebase_timeout_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cycle_timebase_timeout_unit: wrapping cycle counter with time conversions
// Tick/clear update the counter; queries return count, elapsed cycles,
// cycles/us conversions and a timeout flag through one shared
// multiplier and a one-bit-per-cycle restoring divider.
// ----------------------------------------------------------------------------
// tick and clear update the counter and give no beat; now, elapsed and
//   zero-frequency errors give a registered result in the cycle after the input beat
// conversions and timeout checks pass through multiply, load, 64 divider steps and
//   finish before their result; the next beat is taken once the unit is back in idle
// one item in flight at a time; finish stretches while a result waits
// rst (synchronous) clears the counter, sets frequency to 1 MHz, empties output

module cycle_timebase_timeout_unit (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_wen,
  input  logic [31:0] cfg_wdata,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  func,
  input  logic [31:0] operand_value,
  input  logic [31:0] timeout_us,
  // output channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] result_value,
  output logic        elapsed_flag,
  output logic [1:0]  status
);

  localparam int CW = ctt_pkg::COUNTER_WIDTH;
  localparam int DW = ctt_pkg::DIVIDEND_WIDTH;

  ctt_pkg::state_t state, state_next;

  logic [CW-1:0]   cycle_counter;
  logic [31:0]     freq;
  ctt_pkg::func_t  op_func;
  logic [31:0]     op_operand;
  logic [31:0]     op_duration;
  logic [63:0]     product;
  logic [31:0]     divisor;
  logic [31:0]     rem;
  logic [DW-1:0]   quo;
  logic [ctt_pkg::DIV_CNT_WIDTH-1:0] div_cnt;

  ctt_pkg::func_t  in_func;
  logic            accept;
  logic            slot_free;
  logic            no_result;
  logic            out_load;
  logic [31:0]     out_value_d;
  logic            out_flag_d;
  ctt_pkg::status_t out_status_d;

  logic [31:0]     mul_a;
  logic [31:0]     mul_b;
  logic [63:0]     dividend;
  logic [32:0]     rem_sh;
  logic [33:0]     diff;
  logic            ge;
  logic [CW-1:0]   el_in;
  logic [CW-1:0]   el_op;
  logic            quo_hi;

  assign in_func   = ctt_pkg::func_t'(func);
  assign slot_free = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;

  // elapsed cycles, modulo the counter width
  assign el_in  = cycle_counter - operand_value[CW-1:0];
  assign el_op  = cycle_counter - op_operand[CW-1:0];
  assign quo_hi = |quo[DW-1:32];

  // shared multiplier operands
  assign mul_a = (op_func == ctt_pkg::FN_TIMEOUT_CHECK) ? op_duration : op_operand;
  assign mul_b = (op_func == ctt_pkg::FN_CYCLES_TO_US) ? ctt_pkg::US_PER_SECOND : freq;

  // divider load: ceil rounding for us to cycles
  assign dividend = (op_func == ctt_pkg::FN_CYCLES_TO_US) ? product
                  : product + {32'd0, ctt_pkg::US_ROUND_UP};

  // one restoring divider step
  assign rem_sh = {rem, quo[DW-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, divisor};
  assign ge     = !diff[33];

  // beats that leave no result
  always_comb begin
    unique case (in_func)
      ctt_pkg::FN_TICK, ctt_pkg::FN_CLEAR: no_result = 1'b1;
      ctt_pkg::FN_NOW, ctt_pkg::FN_ELAPSED, ctt_pkg::FN_CYCLES_TO_US,
      ctt_pkg::FN_US_TO_CYCLES, ctt_pkg::FN_TIMEOUT_CHECK: no_result = 1'b0;
      default: no_result = 1'b1;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ctt_pkg::S_IDLE: begin
        if (accept && freq != 32'd0 &&
            (in_func == ctt_pkg::FN_CYCLES_TO_US || in_func == ctt_pkg::FN_US_TO_CYCLES ||
             in_func == ctt_pkg::FN_TIMEOUT_CHECK)) begin
          state_next = ctt_pkg::S_MUL;
        end
      end
      ctt_pkg::S_MUL:  state_next = ctt_pkg::S_LOAD;
      ctt_pkg::S_LOAD: state_next = ctt_pkg::S_DIV;
      ctt_pkg::S_DIV: begin
        if (div_cnt == '0) state_next = ctt_pkg::S_FIN;
      end
      ctt_pkg::S_FIN: begin
        if (slot_free) state_next = ctt_pkg::S_IDLE;
      end
      default: state_next = ctt_pkg::S_IDLE;
    endcase
  end

  // handshake and result selection
  always_comb begin
    in_ready     = 1'b0;
    out_load     = 1'b0;
    out_value_d  = 32'd0;
    out_flag_d   = 1'b0;
    out_status_d = ctt_pkg::STATUS_OK;
    unique case (state)
      ctt_pkg::S_IDLE: begin
        in_ready = slot_free || no_result;
        if (accept) begin
          unique case (in_func)
            ctt_pkg::FN_NOW: begin
              out_load    = 1'b1;
              out_value_d = 32'(cycle_counter);
            end
            ctt_pkg::FN_ELAPSED: begin
              out_load    = 1'b1;
              out_value_d = 32'(el_in);
            end
            ctt_pkg::FN_CYCLES_TO_US, ctt_pkg::FN_US_TO_CYCLES,
            ctt_pkg::FN_TIMEOUT_CHECK: begin
              if (freq == 32'd0) begin
                out_load     = 1'b1;
                out_status_d = ctt_pkg::STATUS_IO_ERROR;
              end
            end
            default: out_load = 1'b0;
          endcase
        end
      end
      ctt_pkg::S_FIN: begin
        out_load = slot_free;
        if (op_func == ctt_pkg::FN_TIMEOUT_CHECK) begin
          if (quo_hi || quo[31:0] > ctt_pkg::MAX_TIMEOUT_CYCLES) begin
            out_status_d = ctt_pkg::STATUS_OUT_OF_RANGE;
          end else begin
            out_flag_d = (32'(el_op) >= quo[31:0]);
          end
        end else if (quo_hi) begin
          out_status_d = ctt_pkg::STATUS_OUT_OF_RANGE;
        end else begin
          out_value_d = quo[31:0];
        end
      end
      default: in_ready = 1'b0;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ctt_pkg::S_IDLE;
      cycle_counter <= '0;
      freq          <= ctt_pkg::FREQ_RESET;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wen) freq <= cfg_wdata;
      if (accept && in_func == ctt_pkg::FN_TICK) cycle_counter <= cycle_counter + CW'(1);
      if (accept && in_func == ctt_pkg::FN_CLEAR) cycle_counter <= '0;
      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_func     <= in_func;
      op_operand  <= operand_value;
      op_duration <= timeout_us;
    end
    if (state == ctt_pkg::S_MUL) product <= 64'(mul_a) * 64'(mul_b);
    if (state == ctt_pkg::S_LOAD) begin
      quo     <= dividend;
      rem     <= 32'd0;
      div_cnt <= ctt_pkg::DIV_LAST_STEP;
      divisor <= (op_func == ctt_pkg::FN_CYCLES_TO_US) ? freq : ctt_pkg::US_PER_SECOND;
    end
    if (state == ctt_pkg::S_DIV) begin
      rem     <= ge ? diff[31:0] : rem_sh[31:0];
      quo     <= {quo[DW-2:0], ge};
      div_cnt <= div_cnt - ctt_pkg::DIV_CNT_WIDTH'(1);
    end
    if (out_load) begin
      result_value <= out_value_d;
      elapsed_flag <= out_flag_d;
      status       <= out_status_d;
    end
  end

  // divider runs its last step into the finish cycle
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    (state == ctt_pkg::S_DIV && div_cnt == '0) |=> state == ctt_pkg::S_FIN)
    else $error("divider did not finish after its last step");

  // counter holds while a query is in the sequencer
  a_counter_hold: assert property (@(posedge clk) disable iff (rst)
    (state != ctt_pkg::S_IDLE) |=> $stable(cycle_counter))
    else $error("counter moved during a query");

  // error beats carry zero value and flag
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ctt_pkg::STATUS_OK) |-> (result_value == 32'd0 && !elapsed_flag))
    else $error("error result with nonzero payload");

  // no query taken while the sequencer is busy
  a_busy_ready: assert property (@(posedge clk) disable iff (rst)
    (state != ctt_pkg::S_IDLE) |-> !in_ready)
    else $error("input taken while busy");

endmodule
